// ===== rtl/cab_pkg.sv =====
// shared types, constants and helpers of the checkerboard alpha backdrop
// no dependencies; used by every module in rtl/
`default_nettype none

package cab_pkg;

   // tile and cell geometry; tile sizes are powers of two, cells are 16 pixels
   localparam int TILE_W_BITS = 6;
   localparam int TILE_H_BITS = 6;
   localparam int CELL_BITS   = 4;

   // checker greys and alpha
   localparam logic [7:0] GREY_DARK  = 8'd128;
   localparam logic [7:0] GREY_STEP  = 8'd63;
   localparam logic [7:0] GREY_LIGHT = GREY_DARK + GREY_STEP;
   localparam logic [7:0] FULL_ALPHA = 8'd255;

   // datapath widths
   localparam int COL_W  = 12;
   localparam int ROW_W  = 16;
   localparam int LINE_W = 13;
   localparam int SIZE_W = 16;
   localparam int POS_W  = 18;
   localparam int PROD_W = POS_W + SIZE_W + 1;
   localparam int MAG_W  = 33;
   localparam int CNT_W  = $clog2(MAG_W);
   localparam int DIFF_W = 17;

   localparam logic [LINE_W-1:0] MAX_LINE = 13'd4096;

   // configuration port
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      REG_SCALED_MODE   = 3'd0,
      REG_ORIGIN_X      = 3'd1,
      REG_ORIGIN_Y      = 3'd2,
      REG_LINE_WIDTH    = 3'd3,
      REG_SOURCE_WIDTH  = 3'd4,
      REG_SOURCE_HEIGHT = 3'd5,
      REG_SCALED_WIDTH  = 3'd6,
      REG_SCALED_HEIGHT = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic                     scaled_mode;
      logic signed [15:0]       origin_x;
      logic signed [15:0]       origin_y;
      logic [LINE_W-1:0]        line_width;
      logic [SIZE_W-1:0]        source_width;
      logic [SIZE_W-1:0]        source_height;
      logic [SIZE_W-1:0]        scaled_width;
      logic [SIZE_W-1:0]        scaled_height;
   } cfg_type;

   // one classified pixel waiting for the back end
   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic [7:0]               alpha;
      logic [7:0]               red;
      logic [7:0]               green;
      logic [7:0]               blue;
   } queue_entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_ABS,
      BK_DIV,
      BK_TILE,
      BK_MIX,
      BK_SUM,
      BK_OUT
   } back_state_type;

   // grey of the checker cell from the cell bits of both tile coordinates
   function automatic logic [7:0] cell_grey(input logic cell_x, input logic cell_y);
      return (cell_x ^ cell_y) ? GREY_LIGHT : GREY_DARK;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cab_front.sv =====
// front end: accepts pixel beats, tracks column and row, forms the tile origin position
// depends on cab_pkg
`default_nettype none

module cab_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cab_pkg::cfg_type           cfg,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_frame_start,
   input  wire logic [7:0]                 req_pixel_alpha,
   input  wire logic [7:0]                 req_pixel_red,
   input  wire logic [7:0]                 req_pixel_green,
   input  wire logic [7:0]                 req_pixel_blue,
   output logic                            push_valid,
   input  wire logic                       push_ready,
   output cab_pkg::queue_entry_type        push_data
);

   logic [cab_pkg::COL_W-1:0]  column_ff, column_in, col_eff;
   logic [cab_pkg::ROW_W-1:0]  row_ff, row_in, row_eff;
   logic [cab_pkg::LINE_W-1:0] col_next;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // frame start restarts the counters for this beat
   always_comb begin
      col_eff  = req_frame_start ? '0 : column_ff;
      row_eff  = req_frame_start ? '0 : row_ff;
      col_next = {1'b0, col_eff} + 13'd1;
   end

   // advance position on every accepted beat
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (req_valid && push_ready) begin
         if (col_next >= cfg.line_width) begin
            column_in = '0;
            row_in    = row_eff + 16'd1;
         end else begin
            column_in = col_next[cab_pkg::COL_W-1:0];
            row_in    = row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   // positions relative to the origin, sign extended
   always_comb begin
      push_data.pos_x = {{2{cfg.origin_x[15]}}, cfg.origin_x} + {6'd0, col_eff};
      push_data.pos_y = {{2{cfg.origin_y[15]}}, cfg.origin_y} + {2'd0, row_eff};
      push_data.alpha = req_pixel_alpha;
      push_data.red   = req_pixel_red;
      push_data.green = req_pixel_green;
      push_data.blue  = req_pixel_blue;
   end

endmodule

`default_nettype wire

// ===== rtl/cab_queue.sv =====
// short queue between front and back ends, register based
// depends on cab_pkg
`default_nettype none

module cab_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_valid,
   output logic                            push_ready,
   input  wire cab_pkg::queue_entry_type   push_data,
   output logic                            pop_valid,
   input  wire logic                       pop_ready,
   output cab_pkg::queue_entry_type        pop_data
);

   cab_pkg::queue_entry_type        entry_ff [cab_pkg::QUEUE_DEPTH];
   logic [cab_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [cab_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [cab_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            do_push, do_pop;

   assign push_ready = (count_ff != cab_pkg::QCNT_W'(cab_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == cab_pkg::QPTR_W'(cab_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == cab_pkg::QPTR_W'(cab_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cab_back.sv =====
// back end: scaled tile position (multiply, bit-serial divide), checker grey, blend
// depends on cab_pkg
`default_nettype none

module cab_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cab_pkg::cfg_type           cfg,
   input  wire logic                       pop_valid,
   output logic                            pop_ready,
   input  wire cab_pkg::queue_entry_type   pop_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [7:0]                      rsp_out_red,
   output logic [7:0]                      rsp_out_green,
   output logic [7:0]                      rsp_out_blue
);

   cab_pkg::back_state_type             state_ff, state_in;
   cab_pkg::queue_entry_type            item_ff;

   // control from the output decode
   logic load_item, load_mul, load_abs, step_div, load_tile, load_mix, load_sum;

   // divider datapath, index 0 is horizontal and 1 vertical
   logic signed [cab_pkg::PROD_W-1:0]   prod_ff  [2];
   logic signed [cab_pkg::PROD_W-1:0]   prod_mul [2];
   logic [cab_pkg::PROD_W-1:0]          prod_abs [2];
   logic                                neg_ff   [2];
   logic [cab_pkg::MAG_W-1:0]           dvd_ff   [2];
   logic [cab_pkg::MAG_W-1:0]           dvd_in   [2];
   logic [cab_pkg::SIZE_W-1:0]          rem_ff   [2];
   logic [cab_pkg::SIZE_W-1:0]          rem_in   [2];
   logic [cab_pkg::SIZE_W:0]            rem_sh   [2];
   logic [cab_pkg::SIZE_W-1:0]          divisor  [2];
   logic                                rem_ge   [2];
   logic [cab_pkg::MAG_W-1:0]           quo_sgn  [2];
   logic [cab_pkg::CNT_W-1:0]           cnt_ff;
   logic                                div_last;

   // blend datapath
   logic [7:0]                          grey_ff, grey_direct, grey_scaled;
   logic [7:0]                          pix      [3];
   logic signed [8:0]                   sub      [3];
   logic signed [17:0]                  mix      [3];
   logic signed [cab_pkg::DIFF_W-1:0]   diff_ff  [3];
   logic [cab_pkg::DIFF_W-1:0]          dmag     [3];
   logic [15:0]                         rnd      [3];
   logic [16:0]                         est      [3];
   logic [7:0]                          blended  [3];
   logic [7:0]                          out_ff   [3];

   assign div_last = (cnt_ff == cab_pkg::CNT_W'(cab_pkg::MAG_W - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cab_pkg::BK_IDLE: begin
            if (pop_valid) begin
               state_in = cfg.scaled_mode ? cab_pkg::BK_MUL : cab_pkg::BK_MIX;
            end
         end
         cab_pkg::BK_MUL:  state_in = cab_pkg::BK_ABS;
         cab_pkg::BK_ABS:  state_in = cab_pkg::BK_DIV;
         cab_pkg::BK_DIV: begin
            if (div_last) begin
               state_in = cab_pkg::BK_TILE;
            end
         end
         cab_pkg::BK_TILE: state_in = cab_pkg::BK_MIX;
         cab_pkg::BK_MIX:  state_in = cab_pkg::BK_SUM;
         cab_pkg::BK_SUM:  state_in = cab_pkg::BK_OUT;
         cab_pkg::BK_OUT: begin
            if (rsp_ready) begin
               state_in = cab_pkg::BK_IDLE;
            end
         end
         default:          state_in = cab_pkg::BK_IDLE;
      endcase
   end

   // output decode
   always_comb begin
      pop_ready = 1'b0;
      rsp_valid = 1'b0;
      load_item = 1'b0;
      load_mul  = 1'b0;
      load_abs  = 1'b0;
      step_div  = 1'b0;
      load_tile = 1'b0;
      load_mix  = 1'b0;
      load_sum  = 1'b0;
      case (state_ff)
         cab_pkg::BK_IDLE: begin
            pop_ready = 1'b1;
            load_item = pop_valid;
         end
         cab_pkg::BK_MUL:  load_mul  = 1'b1;
         cab_pkg::BK_ABS:  load_abs  = 1'b1;
         cab_pkg::BK_DIV:  step_div  = 1'b1;
         cab_pkg::BK_TILE: load_tile = 1'b1;
         cab_pkg::BK_MIX:  load_mix  = 1'b1;
         cab_pkg::BK_SUM:  load_sum  = 1'b1;
         cab_pkg::BK_OUT:  rsp_valid = 1'b1;
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cab_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // direct-mode grey straight from the positions
   always_comb begin
      logic [cab_pkg::TILE_W_BITS-1:0] tile_x;
      logic [cab_pkg::TILE_H_BITS-1:0] tile_y;
      tile_x      = pop_data.pos_x[cab_pkg::TILE_W_BITS-1:0];
      tile_y      = pop_data.pos_y[cab_pkg::TILE_H_BITS-1:0];
      grey_direct = cab_pkg::cell_grey(tile_x[cab_pkg::CELL_BITS],
                                       tile_y[cab_pkg::CELL_BITS]);
   end

   // position times source size, magnitude, and one restoring divide step per axis
   always_comb begin
      prod_mul[0] = $signed(item_ff.pos_x) * $signed({1'b0, cfg.source_width});
      prod_mul[1] = $signed(item_ff.pos_y) * $signed({1'b0, cfg.source_height});
      divisor[0]  = cfg.scaled_width;
      divisor[1]  = cfg.scaled_height;
      for (int a = 0; a < 2; a++) begin
         prod_abs[a] = prod_ff[a][cab_pkg::PROD_W-1] ? (~prod_ff[a] + 1'b1) : prod_ff[a];
         rem_sh[a]   = {rem_ff[a], dvd_ff[a][cab_pkg::MAG_W-1]};
         rem_ge[a]   = (rem_sh[a] >= {1'b0, divisor[a]});
         rem_in[a]   = rem_ge[a] ? (rem_sh[a][cab_pkg::SIZE_W-1:0] - divisor[a])
                                 : rem_sh[a][cab_pkg::SIZE_W-1:0];
         dvd_in[a]   = {dvd_ff[a][cab_pkg::MAG_W-2:0], rem_ge[a]};
         quo_sgn[a]  = neg_ff[a] ? (~dvd_ff[a] + 1'b1) : dvd_ff[a];
      end
   end

   // scaled-mode grey from the signed quotients
   always_comb begin
      logic [cab_pkg::TILE_W_BITS-1:0] qtile_x;
      logic [cab_pkg::TILE_H_BITS-1:0] qtile_y;
      qtile_x     = quo_sgn[0][cab_pkg::TILE_W_BITS-1:0];
      qtile_y     = quo_sgn[1][cab_pkg::TILE_H_BITS-1:0];
      grey_scaled = cab_pkg::cell_grey(qtile_x[cab_pkg::CELL_BITS],
                                       qtile_y[cab_pkg::CELL_BITS]);
   end

   // differences times alpha
   always_comb begin
      pix[0] = item_ff.red;
      pix[1] = item_ff.green;
      pix[2] = item_ff.blue;
      for (int c = 0; c < 3; c++) begin
         sub[c] = $signed({1'b0, pix[c]}) - $signed({1'b0, grey_ff});
         mix[c] = sub[c] * $signed({1'b0, item_ff.alpha});
      end
   end

   // rounded divide by 255, sign restored, added to the grey; opaque pixels pass unchanged
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dmag[c] = diff_ff[c][cab_pkg::DIFF_W-1] ? (~diff_ff[c] + 1'b1) : diff_ff[c];
         rnd[c]  = dmag[c][15:0] + 16'd127;
         est[c]  = {1'b0, rnd[c]} + {9'd0, rnd[c][15:8]} + 17'd1;
         if (item_ff.alpha == cab_pkg::FULL_ALPHA) begin
            blended[c] = pix[c];
         end else if (diff_ff[c][cab_pkg::DIFF_W-1]) begin
            blended[c] = grey_ff - est[c][15:8];
         end else begin
            blended[c] = grey_ff + est[c][15:8];
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (load_item) begin
         item_ff <= pop_data;
         grey_ff <= grey_direct;
      end
      if (load_mul) begin
         prod_ff[0] <= prod_mul[0];
         prod_ff[1] <= prod_mul[1];
      end
      if (load_abs) begin
         cnt_ff <= '0;
         for (int a = 0; a < 2; a++) begin
            neg_ff[a] <= prod_ff[a][cab_pkg::PROD_W-1];
            dvd_ff[a] <= prod_abs[a][cab_pkg::MAG_W-1:0];
            rem_ff[a] <= '0;
         end
      end
      if (step_div) begin
         cnt_ff <= cnt_ff + 1'b1;
         for (int a = 0; a < 2; a++) begin
            dvd_ff[a] <= dvd_in[a];
            rem_ff[a] <= rem_in[a];
         end
      end
      if (load_tile) begin
         grey_ff <= grey_scaled;
      end
      if (load_mix) begin
         for (int c = 0; c < 3; c++) begin
            diff_ff[c] <= $signed(mix[c][cab_pkg::DIFF_W-1:0]);
         end
      end
      if (load_sum) begin
         for (int c = 0; c < 3; c++) begin
            out_ff[c] <= blended[c];
         end
      end
   end

   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];

endmodule

`default_nettype wire

// ===== rtl/checkerboard_alpha_backdrop.sv =====
// Composites a stream of ARGB pixels over a grey checkerboard (16-pixel cells, 64x64 tile).
// One pixel is worked at a time; the back end takes no new pixel until it is back in IDLE.
// Direct mode steps through IDLE, MIX, SUM and OUT; scaled mode adds MUL, ABS, a 33-step
// bit-serial divider per axis (DIV) and TILE between IDLE and MIX. A result is held in OUT
// until rsp_ready. A two-entry queue keeps taking beats as long as it has room. Opaque pixels
// pass unchanged. Registers sit at byte address 4*index:
// scaled_mode, origin_x, origin_y, line_width, source_width, source_height, scaled_width,
// scaled_height. Zero sizes read back as 1; a line width above 4096 holds 4096.
// depends on cab_pkg, cab_front, cab_queue, cab_back
`default_nettype none

module checkerboard_alpha_backdrop (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // pixel beats
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_frame_start,
   input  wire logic [7:0]                    req_pixel_alpha,
   input  wire logic [7:0]                    req_pixel_red,
   input  wire logic [7:0]                    req_pixel_green,
   input  wire logic [7:0]                    req_pixel_blue,
   // composited beats
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [7:0]                         rsp_out_red,
   output logic [7:0]                         rsp_out_green,
   output logic [7:0]                         rsp_out_blue,
   // register port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [cab_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [cab_pkg::DATA_W-1:0]    pwdata,
   output logic [cab_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);

   cab_pkg::cfg_type            cfg_ff, cfg_in;
   cab_pkg::csr_reg_type        reg_sel;
   cab_pkg::queue_entry_type    push_data, pop_data;
   logic                        push_valid, push_ready, pop_valid, pop_ready;
   logic                        csr_write;
   logic [cab_pkg::LINE_W-1:0]  line_wr;

   assign pready    = 1'b1;
   assign reg_sel   = cab_pkg::csr_reg_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;
   assign line_wr   = pwdata[cab_pkg::LINE_W-1:0];

   // register writes with size clamping
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            cab_pkg::REG_SCALED_MODE:   cfg_in.scaled_mode = pwdata[0];
            cab_pkg::REG_ORIGIN_X:      cfg_in.origin_x    = $signed(pwdata[15:0]);
            cab_pkg::REG_ORIGIN_Y:      cfg_in.origin_y    = $signed(pwdata[15:0]);
            cab_pkg::REG_LINE_WIDTH: begin
               if (line_wr == '0) begin
                  cfg_in.line_width = 13'd1;
               end else if (line_wr > cab_pkg::MAX_LINE) begin
                  cfg_in.line_width = cab_pkg::MAX_LINE;
               end else begin
                  cfg_in.line_width = line_wr;
               end
            end
            cab_pkg::REG_SOURCE_WIDTH:
               cfg_in.source_width  = (pwdata[15:0] == '0) ? 16'd1 : pwdata[15:0];
            cab_pkg::REG_SOURCE_HEIGHT:
               cfg_in.source_height = (pwdata[15:0] == '0) ? 16'd1 : pwdata[15:0];
            cab_pkg::REG_SCALED_WIDTH:
               cfg_in.scaled_width  = (pwdata[15:0] == '0) ? 16'd1 : pwdata[15:0];
            cab_pkg::REG_SCALED_HEIGHT:
               cfg_in.scaled_height = (pwdata[15:0] == '0) ? 16'd1 : pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scaled_mode   <= 1'b0;
         cfg_ff.origin_x      <= '0;
         cfg_ff.origin_y      <= '0;
         cfg_ff.line_width    <= 13'd1;
         cfg_ff.source_width  <= 16'd1;
         cfg_ff.source_height <= 16'd1;
         cfg_ff.scaled_width  <= 16'd1;
         cfg_ff.scaled_height <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register readback
   always_comb begin
      case (reg_sel)
         cab_pkg::REG_SCALED_MODE:   prdata = {31'd0, cfg_ff.scaled_mode};
         cab_pkg::REG_ORIGIN_X:      prdata = {{16{cfg_ff.origin_x[15]}}, cfg_ff.origin_x};
         cab_pkg::REG_ORIGIN_Y:      prdata = {{16{cfg_ff.origin_y[15]}}, cfg_ff.origin_y};
         cab_pkg::REG_LINE_WIDTH:    prdata = {19'd0, cfg_ff.line_width};
         cab_pkg::REG_SOURCE_WIDTH:  prdata = {16'd0, cfg_ff.source_width};
         cab_pkg::REG_SOURCE_HEIGHT: prdata = {16'd0, cfg_ff.source_height};
         cab_pkg::REG_SCALED_WIDTH:  prdata = {16'd0, cfg_ff.scaled_width};
         cab_pkg::REG_SCALED_HEIGHT: prdata = {16'd0, cfg_ff.scaled_height};
         default:                    prdata = '0;
      endcase
   end

   // position tracking and classification
   cab_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_frame_start (req_frame_start),
      .req_pixel_alpha (req_pixel_alpha),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   // decoupling queue
   cab_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // tile lookup and blend
   cab_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue)
   );

endmodule

`default_nettype wire
